FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the varint codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent true at an edge implies the consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Antecedent true at an edge implies the consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/vic_pkg.sv
// Package with types and constants of the varint codec.
`timescale 1ns / 1ps

package vic_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic WIDTH_SEL_32 = 1'b0;
  localparam logic WIDTH_SEL_64 = 1'b1;

  localparam logic [3:0] MAX_BYTES_32 = 4'd5;
  localparam logic [3:0] MAX_BYTES_64 = 4'd10;

  localparam logic [63:0] MASK_32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MASK_64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ENC_BYTE  = 2'd0,
    KIND_DEC_VALUE = 2'd1,
    KIND_DEC_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    logic        mode;
    logic [63:0] enc_value;
    logic [7:0]  in_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [63:0] dec_value;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic enc_load;
    logic enc_step;
    logic dec_take;
  } vic_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dec_emit;
    logic enc_last;
  } vic_sts_t;

endpackage

FILE: rtl/vic_datapath.sv
// Datapath of the varint codec: encode shifter, decode accumulator, result register.
`timescale 1ns / 1ps

module vic_datapath import vic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  input  in_item_t  in_data_i,
  input  vic_cmd_t  cmd_i,
  output vic_sts_t  sts_o,
  output out_item_t out_data_o
);

  logic        width_q, width_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  seen_q, seen_d;
  logic [63:0] sh_q, sh_d;
  out_item_t   out_q, out_d;

  logic [63:0] mask;
  logic [63:0] sh_rest;
  logic [7:0]  enc_byte;
  logic [3:0]  n_byte;
  logic [3:0]  max_n;
  logic        more;
  logic        dec_err;
  logic [6:0]  shift_wide;
  logic [5:0]  shift_amt;
  logic [63:0] acc_sum;

  always_comb begin
    mask     = (width_q == WIDTH_SEL_64) ? MASK_64 : MASK_32;
    sh_rest  = {7'd0, sh_q[63:7]};
    enc_byte = {(sh_rest != 64'd0), sh_q[6:0]};

    // Byte number in the current run, and its bit position (seven per byte).
    n_byte     = seen_q + 4'd1;
    max_n      = (width_q == WIDTH_SEL_64) ? MAX_BYTES_64 : MAX_BYTES_32;
    more       = in_data_i.in_byte[7];
    dec_err    = (n_byte > max_n) || (more && (n_byte == max_n));
    shift_wide = {seen_q, 3'b000} - {3'b000, seen_q};
    shift_amt  = shift_wide[5:0];
    // Earlier groups sit strictly below the new one, so an OR is the sum.
    acc_sum    = (acc_q | (64'(in_data_i.in_byte[6:0]) << shift_amt)) & mask;
  end

  assign sts_o.dec_emit = dec_err || !more;
  assign sts_o.enc_last = (sh_rest == 64'd0);

  always_comb begin
    width_d = width_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    sh_d    = sh_q;
    out_d   = out_q;

    if (cfg_we_i) begin
      width_d = cfg_data_i;
    end

    if (cmd_i.enc_load) begin
      sh_d = in_data_i.enc_value & mask;
    end else if (cmd_i.enc_step) begin
      sh_d            = sh_rest;
      out_d.kind      = KIND_ENC_BYTE;
      out_d.out_byte  = enc_byte;
      out_d.dec_value = 64'd0;
      out_d.last      = (sh_rest == 64'd0);
    end

    if (cmd_i.dec_take) begin
      if (dec_err || !more) begin
        acc_d           = 64'd0;
        seen_d          = 4'd0;
        out_d.kind      = dec_err ? KIND_DEC_ERROR : KIND_DEC_VALUE;
        out_d.out_byte  = 8'd0;
        out_d.dec_value = dec_err ? 64'd0 : acc_sum;
        out_d.last      = 1'b1;
      end else begin
        acc_d  = acc_sum;
        seen_d = n_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_SEL_64;
      acc_q   <= 64'd0;
      seen_q  <= 4'd0;
    end else begin
      width_q <= width_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

FILE: rtl/vic_ctrl.sv
// Controller of the varint codec: item acceptance, encode sequencing, result valid.
`timescale 1ns / 1ps

module vic_ctrl import vic_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_mode_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  vic_sts_t sts_i,
  output vic_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ENC  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic in_ready;
  logic in_take;
  logic out_load;

  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    in_ready = (state_q == ST_IDLE) && out_free;
    in_take  = in_valid_i && in_ready;

    cmd_o.enc_load = in_take && (in_mode_i == MODE_ENCODE);
    cmd_o.dec_take = in_take && (in_mode_i == MODE_DECODE);
    cmd_o.enc_step = (state_q == ST_ENC) && out_free;

    out_load = cmd_o.enc_step || (cmd_o.dec_take && sts_i.dec_emit);

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.enc_load) begin
          state_d = ST_ENC;
        end
      end
      ST_ENC: begin
        if (cmd_o.enc_step && sts_i.enc_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/varint_7bit_codec_core.sv
// Top level of the unsigned 7-bit varint (LEB128) codec.
`timescale 1ns / 1ps

// The block takes one item at a time on the input channel (in_valid_i, in_stall_o,
// in_data_i) and returns results on the output channel (out_valid_o, out_stall_i,
// out_data_o). A transfer happens at a clock edge where valid is high and stall low.
// An encode item (mode 0) is captured into a shift register; the encoder then
// emits one byte per cycle while the receiver does not stall, 1 to 5 bytes at
// 32-bit width and 1 to 10 at 64-bit width. The block has a single output register
// and takes no new item until the last byte of a value has been emitted.
// A decode item (mode 1) is one byte; a final byte or an overlength byte loads its
// result into the output register at the input transfer edge, so it appears on the
// output in the cycle after the input transfer. A decode byte may follow every
// cycle while the output side keeps up.
// The width register is written on the cfg channel; cfg_ready_o is always high,
// and writes are meant to happen only while the block is idle.
// Reset selects 64-bit width, clears the decoder run and empties the output.
// While a result waits and the receiver stalls, the result register holds its value
// and no new input is taken, so an encode run simply pauses between bytes.

`include "assert_macros.svh"

module varint_7bit_codec_core import vic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  vic_cmd_t cmd;
  vic_sts_t sts;
  logic     cfg_we;

  // The width register can always take a write.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  vic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vic_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // An input transfer never lands while a result is blocked in the output register.
  `ASSERT_IMPLIES(a_in_take_out_free, clk_i, rst_ni,
                  in_valid_i && !in_stall_o, !out_valid_o || !out_stall_i)

  // After an encode value is taken, the block is busy emitting its bytes.
  `ASSERT_NEXT(a_enc_busy, clk_i, rst_ni,
               in_valid_i && !in_stall_o && (in_data_i.mode == MODE_ENCODE), in_stall_o)

  // Decoder results are always the single, final result of their item.
  `ASSERT_IMPLIES(a_dec_last, clk_i, rst_ni,
                  out_valid_o && (out_data_o.kind != KIND_ENC_BYTE), out_data_o.last)

  // The command strobes to the datapath are mutually exclusive.
  `ASSERT_IMPLIES(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd))

endmodule

FILE: bench/varint_7bit_codec_core_test.sv
// Self-checking testbench for the varint codec core with directed and random traffic.
`timescale 1ns / 1ps

module varint_7bit_codec_core_test;
  import vic_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  // Mirror of the block: width register and decoder run.
  logic        width_64 = WIDTH_SEL_64;
  logic [63:0] dec_acc = '0;
  logic [3:0]  dec_count = '0;
  out_item_t   due_out[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int errors = 0;
  int items_sent = 0;
  int enc_items = 0;
  int dec_items = 0;
  int values_decoded = 0;
  int overlength_hits = 0;
  int results_checked = 0;
  int cfg_writes = 0;

  varint_7bit_codec_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("run timed out with %0d results pending", due_out.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall: random per cycle, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every result transfer is compared with the oldest expected result.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_out.size() == 0) begin
        $error("unexpected result: kind %0d, byte %0h, value %0h, last %0b",
               out_data.kind, out_data.out_byte, out_data.dec_value, out_data.last);
        errors++;
      end else begin
        want = due_out.pop_front();
        results_checked++;
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          errors++;
        end
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.dec_value !== want.dec_value) begin
          $error("dec_value: expected %h, got %h", want.dec_value, out_data.dec_value);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  function automatic void expect_result(kind_e k, logic [7:0] b, logic [63:0] v, logic l);
    out_item_t r;
    r.kind = k;
    r.out_byte = b;
    r.dec_value = v;
    r.last = l;
    due_out.push_back(r);
  endfunction

  // Works out the results of one accepted item and advances the decoder run.
  function automatic void varint_step(in_item_t item);
    logic [63:0] mask;
    logic [63:0] v;
    logic [7:0]  b;
    logic [4:0]  n;
    logic [4:0]  maxb;
    logic        more;
    int          k;
    int          shift;
    mask = width_64 ? MASK_64 : MASK_32;
    maxb = width_64 ? MAX_BYTES_64 : MAX_BYTES_32;
    if (item.mode == MODE_ENCODE) begin
      enc_items++;
      v = item.enc_value & mask;
      k = 0;
      do begin
        b = {1'b0, v[6:0]};
        v = v >> 7;
        b[7] = (v != 0);
        expect_result(KIND_ENC_BYTE, b, '0, v == 0);
        k++;
      end while (v != 0 && k < 10);
    end else begin
      dec_items++;
      n = {1'b0, dec_count} + 5'd1;
      more = item.in_byte[7];
      if (n > maxb || (more && n == maxb)) begin
        // Run too long for the width: one error result, decoder cleared.
        dec_acc = '0;
        dec_count = '0;
        overlength_hits++;
        expect_result(KIND_DEC_ERROR, '0, '0, 1'b1);
      end else begin
        shift = (int'(n) - 1) * 7;
        if (shift < 64) begin
          dec_acc = (dec_acc + ({57'd0, item.in_byte[6:0]} << shift)) & mask;
        end
        if (more) begin
          dec_count = n[3:0];
        end else begin
          values_decoded++;
          expect_result(KIND_DEC_VALUE, '0, dec_acc & mask, 1'b1);
          dec_acc = '0;
          dec_count = '0;
        end
      end
    end
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v >> $urandom_range(63);
  endfunction

  function automatic in_item_t enc_item(logic [63:0] v);
    in_item_t it;
    it.mode = MODE_ENCODE;
    it.enc_value = v;
    it.in_byte = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic in_item_t dec_item(logic [7:0] b);
    in_item_t it;
    it.mode = MODE_DECODE;
    it.enc_value = {$urandom, $urandom};
    it.in_byte = b;
    return it;
  endfunction

  // Offers one item, possibly after a random gap, and returns once it is transferred.
  task automatic send_item(in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    varint_step(item);
  endtask

  // Width writes only happen with the block drained and the input quiet.
  task automatic set_width(logic sel);
    in_valid <= 1'b0;
    while (due_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_64 = sel;
    cfg_writes++;
  endtask

  task automatic test_encode_extremes();
    send_item(enc_item(64'd0));
    send_item(enc_item(64'd127));
    send_item(enc_item(64'd128));
    send_item(enc_item(64'hFFFF_FFFF_FFFF_FFFF));
    send_item(enc_item(64'h8000_0000_0000_0000));
    // At 32 bits the upper half of the value must be ignored.
    set_width(WIDTH_SEL_32);
    send_item(enc_item(64'hFFFF_FFFF_0000_0080));
    send_item(enc_item(64'hFFFF_FFFF_FFFF_FFFF));
  endtask

  task automatic test_decode_wrap_and_overlength();
    // Five full groups at 32 bits: the top payload bits fall off.
    repeat (4) send_item(dec_item(8'hFF));
    send_item(dec_item(8'h7F));
    // Fifth byte still continuing is an overlength run.
    repeat (5) send_item(dec_item(8'h80));
  endtask

  task automatic test_width_change_midrun();
    set_width(WIDTH_SEL_64);
    send_item(dec_item(8'h00));
    repeat (6) send_item(dec_item(8'h81));
    // The run is already past the 32-bit limit, so the next byte is an error.
    set_width(WIDTH_SEL_32);
    send_item(dec_item(8'h05));
  endtask

  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
    int start;
    int r;
    int len;
    int maxb;
    logic broken;
    start = items_sent;
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    while (items_sent - start < n_items) begin
      if ($urandom_range(59) == 0) set_width(1'($urandom_range(1)));
      r = $urandom_range(99);
      if (r < 40) begin
        send_item(enc_item(rand_value()));
      end else if (r < 85) begin
        // Encoded byte run with random payloads; some keep continuing.
        maxb = width_64 ? 10 : 5;
        len = $urandom_range(1, maxb);
        broken = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++) begin
          send_item(dec_item({(i < len - 1) || broken, 7'($urandom_range(127))}));
        end
      end else begin
        send_item(dec_item(8'($urandom_range(255))));
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= hold_req + 1;
    repeat (30) send_item(enc_item(rand_value()));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_encode_extremes();
    test_decode_wrap_and_overlength();
    test_width_change_midrun();
    test_random_traffic(150, 11, 78);
    test_random_traffic(150, 78, 11);
    test_random_traffic(150, 0, 0);
    test_backpressure();

    in_valid <= 1'b0;
    while (due_out.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d items (%0d encodes, %0d decode bytes), checked %0d results,",
             items_sent, enc_items, dec_items, results_checked);
    $display("made %0d width writes, decoded %0d values, saw %0d overlength runs.",
             cfg_writes, values_decoded, overlength_hits);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
